@@ src/dhfk_pkg.sv @@
package dhfk_pkg;

  localparam int JOINTS       = 7;
  localparam int CORDIC_STEPS = 31;
  // fold stage, one stage per rotation step, sign and clamp stage
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int LEN_W        = 26;
  localparam int ANG_W        = 31;
  localparam int POS_W        = 29;
  localparam int CNT_W        = 3;
  localparam int LEN_REGS     = 4;
  localparam int IN_W         = 224;
  localparam int OUT_W        = 376;

  typedef logic signed [ANG_W-1:0] angle_t;
  typedef logic signed [31:0]      q30_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic signed [33:0]      cw_t;

  localparam cw_t HALF_PI_Q30 = 34'sd1686629713;
  localparam cw_t PI_Q30      = 34'sd3373259426;
  localparam cw_t CORDIC_GAIN = 34'sd652032874;
  localparam q30_t ONE_Q30    = 32'sd1073741824;
  localparam pos_t POS_LIMIT  = 29'sd134217728;

  localparam cw_t ATAN_Q30 [CORDIC_STEPS] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
    34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767,
    34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047, 34'sd1023, 34'sd511, 34'sd255,
    34'sd127, 34'sd63, 34'sd31, 34'sd15, 34'sd8, 34'sd4, 34'sd2, 34'sd1
  };

  // link lengths register indexes
  localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
  localparam logic [1:0] REG_UPPER_ARM   = 2'd1;
  localparam logic [1:0] REG_FOREARM     = 2'd2;
  localparam logic [1:0] REG_FLANGE      = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    q30_t [JOINTS-1:0]    ct;
    q30_t [JOINTS-1:0]    st;
  } side_t;

  typedef struct packed {
    q30_t [8:0] rot;
    pos_t [2:0] pos;
  } pose_t;

  // twist sine of -1 for links 2, 5 and 6
  function automatic logic twist_neg(input logic [2:0] idx);
    return (idx == 3'd1) || (idx == 3'd4) || (idx == 3'd5);
  endfunction

  // links 1, 3, 5 and 7 carry a length
  function automatic logic has_len(input logic [2:0] idx);
    return !idx[0];
  endfunction

endpackage

@@ src/dhfk_cordic_lane.sv @@
module dhfk_cordic_lane (
  input  logic            clk,
  input  logic            en,
  input  dhfk_pkg::angle_t angle,
  output dhfk_pkg::q30_t  ct,
  output dhfk_pkg::q30_t  st
);
  import dhfk_pkg::*;

  cw_t  x_r    [CORDIC_STEPS+1];
  cw_t  y_r    [CORDIC_STEPS+1];
  cw_t  z_r    [CORDIC_STEPS+1];
  logic flip_r [CORDIC_STEPS+1];
  q30_t ct_r, st_r;

  cw_t  z_in, z_fold;
  logic flip_in;
  cw_t  xf, yf;

  // scale to q.30 and fold into the half circle
  always_comb begin
    z_in    = 34'(angle) <<< 2;
    z_fold  = z_in;
    flip_in = 1'b0;
    if (z_in > HALF_PI_Q30) begin
      z_fold  = z_in - PI_Q30;
      flip_in = 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      z_fold  = z_in + PI_Q30;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= z_fold;
      flip_r[0] <= flip_in;
    end
  end

  // one rotation step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_Q30[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_Q30[i];
        end
      end
    end
  end

  // undo the fold and clamp to unit range
  always_comb begin
    xf = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    yf = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    if (xf > 34'(ONE_Q30))       xf = 34'(ONE_Q30);
    else if (xf < -34'(ONE_Q30)) xf = -34'(ONE_Q30);
    if (yf > 34'(ONE_Q30))       yf = 34'(ONE_Q30);
    else if (yf < -34'(ONE_Q30)) yf = -34'(ONE_Q30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct_r <= 32'(xf);
      st_r <= 32'(yf);
    end
  end

  assign ct = ct_r;
  assign st = st_r;

endmodule

@@ src/dhfk_link_stage.sv @@
module dhfk_link_stage (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic [2:0]                            idx,
  input  dhfk_pkg::len_t [dhfk_pkg::LEN_REGS-1:0] lens,
  input  logic                                  vld_i,
  input  dhfk_pkg::side_t                       side_i,
  input  dhfk_pkg::pose_t                       pose_i,
  output logic                                  vld_o,
  output dhfk_pkg::side_t                       side_o,
  output dhfk_pkg::pose_t                       pose_o
);
  import dhfk_pkg::*;

  logic                vld1_r, vld2_r, act_r;
  side_t               side1_r, side2_r;
  pose_t               pose1_r, pose2_r;
  logic signed [63:0]  pa_r [3];
  logic signed [63:0]  pb_r [3];
  logic signed [63:0]  pc_r [3];
  logic signed [63:0]  pe_r [3];
  logic signed [58:0]  pd_r [3];
  q30_t                w_r  [3];

  q30_t                ct, st;
  logic signed [26:0]  d;
  q30_t                u [3];
  q30_t                w [3];
  logic                act, neg;
  pose_t               pose_nxt;
  logic signed [64:0]  s0, s1;
  logic signed [34:0]  r0, r1;
  logic signed [29:0]  pr;
  logic signed [30:0]  pn;

  // pick this link's angle and fixed twist terms
  always_comb begin
    ct  = side_i.ct[idx];
    st  = side_i.st[idx];
    act = idx < side_i.count;
    neg = twist_neg(idx);
    d   = has_len(idx) ? {1'b0, lens[idx[2:1]]} : '0;
    for (int r = 0; r < 3; r++) begin
      if (idx == '0) begin
        u[r] = pose_i.rot[r*3+1];
        w[r] = pose_i.rot[r*3+2];
      end else begin
        u[r] = neg ? -pose_i.rot[r*3+2] : pose_i.rot[r*3+2];
        w[r] = neg ? pose_i.rot[r*3+1] : -pose_i.rot[r*3+1];
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_i;
      pose1_r <= pose_i;
      act_r   <= act;
      for (int r = 0; r < 3; r++) begin
        pa_r[r] <= pose_i.rot[r*3] * ct;
        pb_r[r] <= u[r] * st;
        pc_r[r] <= u[r] * ct;
        pe_r[r] <= pose_i.rot[r*3] * st;
        pd_r[r] <= d * w[r];
        w_r[r]  <= w[r];
      end
    end
  end

  // sums, rounding and clamping
  always_comb begin
    pose_nxt = pose1_r;
    s0 = '0;
    s1 = '0;
    r0 = '0;
    r1 = '0;
    pr = '0;
    pn = '0;
    if (act_r) begin
      for (int r = 0; r < 3; r++) begin
        s0 = 65'(pa_r[r]) + 65'(pb_r[r]) + (65'sd1 <<< 29);
        s1 = 65'(pc_r[r]) - 65'(pe_r[r]) + (65'sd1 <<< 29);
        r0 = 35'(s0 >>> 30);
        r1 = 35'(s1 >>> 30);
        if (r0 > 35'(ONE_Q30))       r0 = 35'(ONE_Q30);
        else if (r0 < -35'(ONE_Q30)) r0 = -35'(ONE_Q30);
        if (r1 > 35'(ONE_Q30))       r1 = 35'(ONE_Q30);
        else if (r1 < -35'(ONE_Q30)) r1 = -35'(ONE_Q30);
        pose_nxt.rot[r*3]   = 32'(r0);
        pose_nxt.rot[r*3+1] = 32'(r1);
        pose_nxt.rot[r*3+2] = w_r[r];
        pr = 30'((60'(pd_r[r]) + (60'sd1 <<< 29)) >>> 30);
        pn = 31'(pose1_r.pos[r]) + 31'(pr);
        if (pn > 31'(POS_LIMIT))       pn = 31'(POS_LIMIT);
        else if (pn < -31'(POS_LIMIT)) pn = -31'(POS_LIMIT);
        pose_nxt.pos[r] = 29'(pn);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side1_r;
      pose2_r <= pose_nxt;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  assign vld_o  = vld2_r;
  assign side_o = side2_r;
  assign pose_o = pose2_r;

endmodule

@@ src/dh_forward_kinematics_7dof_unit.sv @@
// path from input word to output word: sine/cosine lanes, link stages, then the output register
// throughput: one word per cycle; set by the fully pipelined cordic lanes and link stages
// a stalled output holds the whole pipeline, so ready follows the output register
// reset (synchronous, active low) clears all valid flags and loads the default lengths
module dh_forward_kinematics_7dof_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // angle_1..angle_7 (31 bits each), joint_count (3), zero pad (4)
  input  logic [dhfk_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // rot_00..rot_22 (32 bits each), pos_x, pos_y, pos_z (29 each), zero pad (1)
  output logic [dhfk_pkg::OUT_W-1:0]   out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_addr,
  input  logic [dhfk_pkg::LEN_W-1:0]   cfg_wdata
);
  import dhfk_pkg::*;

  len_t [LEN_REGS-1:0]  len_r;
  logic                 vld_dly_r [CORDIC_LAT];
  logic [CNT_W-1:0]     cnt_dly_r [CORDIC_LAT];
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;

  logic                 en;
  logic [CNT_W-1:0]     cnt_in;
  q30_t [JOINTS-1:0]    lane_ct, lane_st;
  logic                 lk_vld  [JOINTS+1];
  side_t                lk_side [JOINTS+1];
  pose_t                lk_pose [JOINTS+1];
  pose_t                ident;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // link length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r[REG_BASE_HEIGHT] <= 26'd5704253;
      len_r[REG_UPPER_ARM]   <= 26'd6710886;
      len_r[REG_FOREARM]     <= 26'd6710886;
      len_r[REG_FLANGE]      <= 26'd2113929;
    end else if (cfg_wr_en) begin
      len_r[cfg_addr] <= cfg_wdata;
    end
  end

  // sine and cosine lanes, one per joint
  for (genvar k = 0; k < JOINTS; k++) begin : g_lane
    dhfk_cordic_lane u_lane (
      .clk   (clk),
      .en    (en),
      .angle (in_tdata[k*ANG_W +: ANG_W]),
      .ct    (lane_ct[k]),
      .st    (lane_st[k])
    );
  end

  // joint count capped at the joint total
  assign cnt_in = (in_tdata[JOINTS*ANG_W +: CNT_W] > CNT_W'(JOINTS)) ?
                  CNT_W'(JOINTS) : in_tdata[JOINTS*ANG_W +: CNT_W];

  // count and valid follow the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      cnt_dly_r[0] <= cnt_in;
      for (int i = 1; i < CORDIC_LAT; i++) cnt_dly_r[i] <= cnt_dly_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORDIC_LAT; i++) vld_dly_r[i] <= 1'b0;
    end else if (en) begin
      vld_dly_r[0] <= in_tvalid;
      for (int i = 1; i < CORDIC_LAT; i++) vld_dly_r[i] <= vld_dly_r[i-1];
    end
  end

  // identity pose into the link chain
  always_comb begin
    ident = '0;
    ident.rot[0] = ONE_Q30;
    ident.rot[4] = ONE_Q30;
    ident.rot[8] = ONE_Q30;
  end

  assign lk_vld[0]        = vld_dly_r[CORDIC_LAT-1];
  assign lk_side[0].count = cnt_dly_r[CORDIC_LAT-1];
  assign lk_side[0].ct    = lane_ct;
  assign lk_side[0].st    = lane_st;
  assign lk_pose[0]       = ident;

  // chain of link transforms
  for (genvar k = 0; k < JOINTS; k++) begin : g_link
    dhfk_link_stage u_link (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .idx    (3'(k)),
      .lens   (len_r),
      .vld_i  (lk_vld[k]),
      .side_i (lk_side[k]),
      .pose_i (lk_pose[k]),
      .vld_o  (lk_vld[k+1]),
      .side_o (lk_side[k+1]),
      .pose_o (lk_pose[k+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lk_vld[JOINTS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) out_data_r[i*32 +: 32] <= lk_pose[JOINTS].rot[i];
      for (int i = 0; i < 3; i++) out_data_r[288 + i*POS_W +: POS_W] <= lk_pose[JOINTS].pos[i];
      out_data_r[OUT_W-1] <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ dv/tb_dh_forward_kinematics_7dof_unit.sv @@
`timescale 1ns / 100ps

module tb_dh_forward_kinematics_7dof_unit;
  import dhfk_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam longint LEN_MAX = 33554432;
  localparam longint ANG_MAX = 843314857;

  // expected pose of one word
  typedef struct {
    longint rot [9];
    longint pos [3];
  } pose_exp_t;

  // pose predictor and store of poses still owed by the block
  class pose_board;
    longint lens [LEN_REGS];
    pose_exp_t owed [$];
    int errors;

    function void reset_lengths();
      lens[0] = 5704253;
      lens[1] = 6710886;
      lens[2] = 6710886;
      lens[3] = 2113929;
      errors = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint rnd30(longint v);
      return (v + (longint'(1) << 29)) >>> 30;
    endfunction

    // folded rotation cordic
    function void sincos(longint z, output longint c, output longint s);
      longint x, y, dx, dy;
      bit flip;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > longint'(HALF_PI_Q30)) begin
        z -= longint'(PI_Q30);
        flip = 1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
        z += longint'(PI_Q30);
        flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = clip(x, -(longint'(1) << 30), longint'(1) << 30);
      s = clip(y, -(longint'(1) << 30), longint'(1) << 30);
    endfunction

    // chain the leading links and note the pose owed
    function void note_word(angle_t ang [JOINTS], logic [CNT_W-1:0] cnt);
      longint one, rot [3][3], nr [3][3], m [3][3], pm [3], p [3];
      longint ct, st, ca, sa, d, acc;
      pose_exp_t e;
      one = longint'(1) << 30;
      for (int r = 0; r < 3; r++) begin
        p[r] = 0;
        for (int c = 0; c < 3; c++) rot[r][c] = (r == c) ? one : 0;
      end
      for (int k = 0; k < cnt; k++) begin
        sincos(longint'(ang[k]) * 4, ct, st);
        ca = (k == 0) ? 1 : 0;
        sa = (k == 0) ? 0 : ((k == 1 || k == 4 || k == 5) ? -1 : 1);
        d = (k % 2 == 0) ? lens[k / 2] : 0;
        m[0][0] = ct;      m[0][1] = -st;     m[0][2] = 0;
        m[1][0] = st * ca; m[1][1] = ct * ca; m[1][2] = -sa * one;
        m[2][0] = st * sa; m[2][1] = ct * sa; m[2][2] = ca * one;
        pm[0] = 0; pm[1] = -d * sa; pm[2] = d * ca;
        for (int r = 0; r < 3; r++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += rot[r][j] * pm[j];
          p[r] = clip(p[r] + rnd30(acc), -(longint'(1) << 27), longint'(1) << 27);
          for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += rot[r][j] * m[j][c];
            nr[r][c] = clip(rnd30(acc), -one, one);
          end
        end
        rot = nr;
      end
      for (int r = 0; r < 3; r++) begin
        e.pos[r] = p[r];
        for (int c = 0; c < 3; c++) e.rot[r * 3 + c] = rot[r][c];
      end
      owed = {owed, e};
    endfunction

    // compare one output word with the oldest owed pose
    function void check_word(logic [OUT_W-1:0] w);
      pose_exp_t e;
      longint got;
      if (owed.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, w);
        errors++;
        return;
      end
      e = owed.pop_front();
      for (int i = 0; i < 9; i++) begin
        got = longint'(q30_t'(w[32 * i +: 32]));
        if (got != e.rot[i]) begin
          $display("%0t: rot[%0d] expected %0d actual %0d", $time, i, e.rot[i], got);
          errors++;
        end
      end
      for (int i = 0; i < 3; i++) begin
        got = longint'(pos_t'(w[288 + POS_W * i +: POS_W]));
        if (got != e.pos[i]) begin
          $display("%0t: pos[%0d] expected %0d actual %0d", $time, i, e.pos[i], got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wr_en;
  logic [1:0] cfg_addr;
  logic [LEN_W-1:0] cfg_wdata;

  pose_board board;
  bit calm;

  dh_forward_kinematics_7dof_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm ? 1'b1 : ($urandom_range(99) < 75);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata);
  end

  task automatic send_word(angle_t ang [JOINTS], logic [CNT_W-1:0] cnt);
    int g;
    logic [IN_W-1:0] w;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    w = '0;
    for (int k = 0; k < JOINTS; k++) w[ANG_W * k +: ANG_W] = ang[k];
    w[ANG_W * JOINTS +: CNT_W] = cnt;
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    board.note_word(ang, cnt);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic set_lengths(longint l0, longint l1, longint l2, longint l3);
    longint v [LEN_REGS];
    logic [1:0] idx [LEN_REGS];
    v = '{l0, l1, l2, l3};
    idx = '{REG_BASE_HEIGHT, REG_UPPER_ARM, REG_FOREARM, REG_FLANGE};
    for (int i = 0; i < LEN_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= v[i][LEN_W-1:0];
      @(posedge clk);
      board.lens[idx[i]] = v[i];
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic angle_t rand_angle();
    int r;
    r = $urandom_range(99);
    if (r < 80) return angle_t'($urandom_range(2 * ANG_MAX) - ANG_MAX);
    if (r < 95) return angle_t'($urandom());
    return (r < 97) ? angle_t'(ANG_MAX) : angle_t'(-ANG_MAX);
  endfunction

  task automatic random_words(int n);
    angle_t a [JOINTS];
    logic [CNT_W-1:0] cnt;
    for (int i = 0; i < n; i++) begin
      if (i % 80 == 0) calm = ($urandom_range(3) == 0);
      if (i == n / 2) drain();
      for (int k = 0; k < JOINTS; k++) a[k] = rand_angle();
      cnt = ($urandom_range(1) == 0) ? 3'd7 : 3'($urandom_range(7));
      send_word(a, cnt);
    end
    calm = 0;
  endtask

  task automatic directed_words();
    angle_t a [JOINTS];
    angle_t sp [8];
    sp = '{angle_t'(0), angle_t'(ANG_MAX), angle_t'(-ANG_MAX),
           angle_t'(421657428), angle_t'(421657429), angle_t'(-421657429),
           {1'b1, 30'd0}, {1'b0, {30{1'b1}}}};
    // every joint count with zero angles, identity included
    for (int c = 0; c <= 7; c++) begin
      for (int k = 0; k < JOINTS; k++) a[k] = '0;
      send_word(a, 3'(c));
    end
    // each special angle on every joint
    foreach (sp[s]) begin
      for (int k = 0; k < JOINTS; k++) a[k] = sp[s];
      send_word(a, 3'd7);
    end
    // angles past the count must not matter
    for (int c = 0; c < 7; c++) begin
      for (int k = 0; k < JOINTS; k++) a[k] = (k < c) ? angle_t'(100000000) : sp[k];
      send_word(a, 3'(c));
    end
  endtask

  initial begin
    board = new();
    board.reset_lengths();
    calm = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();
    random_words(300);
    drain();
    set_lengths(0, 0, 0, 0);
    directed_words();
    random_words(250);
    drain();
    set_lengths(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
    directed_words();
    random_words(300);
    drain();
    set_lengths(LEN_MAX, 0, LEN_MAX, 0);
    random_words(250);
    for (int p = 0; p < 3; p++) begin
      drain();
      set_lengths($urandom_range(LEN_MAX), $urandom_range(LEN_MAX),
                  $urandom_range(LEN_MAX), $urandom_range(LEN_MAX));
      random_words(230);
    end
    drain();

    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 1000000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
